/* rtl/cbd_pkg.sv */
// ----------------------------------------------------------------------------
// cbd_pkg
// Types and constants shared by the cartridge bus decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

	localparam int CHR_BYTES     = 8192;
	localparam int NT_BYTES      = 2048;
	localparam int PRG_RAM_BYTES = 8192;
	localparam int PAL_BYTES     = 32;

	localparam int CHR_AW     = $clog2(CHR_BYTES);
	localparam int NT_AW      = $clog2(NT_BYTES);
	localparam int PRG_RAM_AW = $clog2(PRG_RAM_BYTES);
	localparam int PAL_AW     = $clog2(PAL_BYTES);
	// Widest PRG ROM offset the decoder produces (32 KB window).
	localparam int PRG_IDX_W  = 15;

	// Configuration register indexes.
	localparam logic [1:0] REG_PRG_IS_16K  = 2'd0;
	localparam logic [1:0] REG_CHR_IS_RAM  = 2'd1;
	localparam logic [1:0] REG_MIRROR_MODE = 2'd2;

	typedef enum logic [2:0] {
		OP_CPU_READ  = 3'd0,
		OP_CPU_WRITE = 3'd1,
		OP_PPU_READ  = 3'd2,
		OP_PPU_WRITE = 3'd3,
		OP_PRG_LOAD  = 3'd4,
		OP_CHR_LOAD  = 3'd5
	} op_t;

	// Where the byte of a read comes from.
	typedef enum logic [2:0] {
		SRC_PRG_RAM = 3'd0,
		SRC_PRG_ROM = 3'd1,
		SRC_CPU_OB  = 3'd2,
		SRC_CHR     = 3'd3,
		SRC_NT      = 3'd4,
		SRC_PAL     = 3'd5,
		SRC_PPU_OB  = 3'd6
	} src_t;

	typedef struct packed {
		logic prg_is_16k;
		logic chr_is_ram;
		logic mirror_mode;
	} cfg_t;

	// Decoded access of one beat.
	typedef struct packed {
		logic                  is_read;
		src_t                  src;
		logic                  prg_ram_we;
		logic                  prg_rom_we;
		logic                  chr_we;
		logic                  nt_we;
		logic                  pal_we;
		logic                  cpu_ob_we;
		logic                  ppu_ob_we;
		logic [PRG_RAM_AW-1:0] prg_ram_idx;
		logic [PRG_IDX_W-1:0]  prg_rom_idx;
		logic [CHR_AW-1:0]     chr_idx;
		logic [NT_AW-1:0]      nt_idx;
		logic [PAL_AW-1:0]     pal_idx;
	} acc_t;

endpackage

`default_nettype wire

/* rtl/cartridge_bus_decoder_core.sv */
// ----------------------------------------------------------------------------
// cartridge_bus_decoder_core
// Mapper-0 cartridge decoder: PRG ROM/RAM, CHR, nametables and palette.
// ----------------------------------------------------------------------------
// The block takes one bus beat per clock cycle unless the output side stalls or the
// clearing sweep runs. Writes and loads finish at the edge that accepts them; a read
// is looked up in the synchronous memories at that edge, which fill the read stage,
// and its byte then moves into the output register, so reads may follow each other
// without gaps. After reset the CHR store and PRG RAM are swept to zero, one entry
// per cycle, during which no beat is accepted; register writes are taken as usual.
// PRG_ROM_BYTES must be 16384 or 32768.
`default_nettype none

module cartridge_bus_decoder_core
	import cbd_pkg::*;
#(
	parameter int PRG_ROM_BYTES = 32768
) (
	input  wire         clk,
	input  wire         arst_n,
	// Configuration port
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [3:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// Input stream
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // address [15:0], data_byte [23:16]
	input  wire  [2:0]  s_tuser,   // operation [2:0]
	// Output stream
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata    // read_data [7:0]
);

	localparam int PRG_AW = $clog2(PRG_ROM_BYTES);

	cfg_t                  cfg_q;
	acc_t                  acc;
	logic                  accept;
	logic                  rd_en;
	logic                  adv;
	logic                  clr_active_q;
	logic [CHR_AW-1:0]     clr_cnt_q;

	logic                  valid_s1;
	src_t                  src_s1;
	logic [7:0]            value;
	logic                  out_valid_q;
	logic [7:0]            out_data_q;
	logic [7:0]            cpu_ob_q;
	logic [7:0]            ppu_ob_q;

	logic [7:0]            prg_rom_rd;
	logic [7:0]            prg_ram_rd;
	logic [7:0]            chr_rd;
	logic [7:0]            nt_rd;
	logic [7:0]            pal_rd;

	logic                  chr_we;
	logic [CHR_AW-1:0]     chr_waddr;
	logic [7:0]            chr_wdata;
	logic                  prg_ram_we;
	logic [PRG_RAM_AW-1:0] prg_ram_waddr;
	logic [7:0]            prg_ram_wdata;

	// ---------------- Configuration registers ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_is_16k  <= 1'b0;
			cfg_q.chr_is_ram  <= 1'b1;
			cfg_q.mirror_mode <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[3:2])
				REG_PRG_IS_16K:  cfg_q.prg_is_16k  <= pwdata[0];
				REG_CHR_IS_RAM:  cfg_q.chr_is_ram  <= pwdata[0];
				REG_MIRROR_MODE: cfg_q.mirror_mode <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (paddr[3:2])
			REG_PRG_IS_16K:  prdata[0] = cfg_q.prg_is_16k;
			REG_CHR_IS_RAM:  prdata[0] = cfg_q.chr_is_ram;
			REG_MIRROR_MODE: prdata[0] = cfg_q.mirror_mode;
			default:         prdata    = '0;
		endcase
	end

	// ---------------- Decode and handshake ----------------
	cbd_decode u_decode (
		.operation (s_tuser),
		.address   (s_tdata[15:0]),
		.cfg       (cfg_q),
		.acc       (acc)
	);

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !clr_active_q && (!valid_s1 || adv);
	assign accept   = s_tvalid && s_tready;
	assign rd_en    = accept && acc.is_read;

	// ---------------- Clearing sweep ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_active_q <= 1'b1;
			clr_cnt_q    <= '0;
		end else if (clr_active_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (&clr_cnt_q) begin
				clr_active_q <= 1'b0;
			end
		end
	end

	always_comb begin
		if (clr_active_q) begin
			chr_we        = 1'b1;
			chr_waddr     = clr_cnt_q;
			chr_wdata     = '0;
			prg_ram_we    = 1'b1;
			prg_ram_waddr = clr_cnt_q[PRG_RAM_AW-1:0];
			prg_ram_wdata = '0;
		end else begin
			chr_we        = accept && acc.chr_we;
			chr_waddr     = acc.chr_idx;
			chr_wdata     = s_tdata[23:16];
			prg_ram_we    = accept && acc.prg_ram_we;
			prg_ram_waddr = acc.prg_ram_idx;
			prg_ram_wdata = s_tdata[23:16];
		end
	end

	// ---------------- Memories ----------------
	cbd_ram #(.WIDTH(8), .DEPTH(PRG_ROM_BYTES)) u_prg_rom (
		.clk   (clk),
		.we    (accept && acc.prg_rom_we),
		.waddr (acc.prg_rom_idx[PRG_AW-1:0]),
		.wdata (s_tdata[23:16]),
		.re    (rd_en),
		.raddr (acc.prg_rom_idx[PRG_AW-1:0]),
		.rdata (prg_rom_rd)
	);

	cbd_ram #(.WIDTH(8), .DEPTH(PRG_RAM_BYTES)) u_prg_ram (
		.clk   (clk),
		.we    (prg_ram_we),
		.waddr (prg_ram_waddr),
		.wdata (prg_ram_wdata),
		.re    (rd_en),
		.raddr (acc.prg_ram_idx),
		.rdata (prg_ram_rd)
	);

	cbd_ram #(.WIDTH(8), .DEPTH(CHR_BYTES)) u_chr (
		.clk   (clk),
		.we    (chr_we),
		.waddr (chr_waddr),
		.wdata (chr_wdata),
		.re    (rd_en),
		.raddr (acc.chr_idx),
		.rdata (chr_rd)
	);

	cbd_ram #(.WIDTH(8), .DEPTH(NT_BYTES)) u_nametable (
		.clk   (clk),
		.we    (accept && acc.nt_we),
		.waddr (acc.nt_idx),
		.wdata (s_tdata[23:16]),
		.re    (rd_en),
		.raddr (acc.nt_idx),
		.rdata (nt_rd)
	);

	cbd_ram #(.WIDTH(8), .DEPTH(PAL_BYTES)) u_palette (
		.clk   (clk),
		.we    (accept && acc.pal_we),
		.waddr (acc.pal_idx),
		.wdata (s_tdata[23:16]),
		.re    (rd_en),
		.raddr (acc.pal_idx),
		.rdata (pal_rd)
	);

	// ---------------- Read stage ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || adv) begin
			valid_s1 <= rd_en;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			src_s1 <= acc.src;
		end
	end

	always_comb begin
		unique case (src_s1)
			SRC_PRG_RAM: value = prg_ram_rd;
			SRC_PRG_ROM: value = prg_rom_rd;
			SRC_CPU_OB:  value = cpu_ob_q;
			SRC_CHR:     value = chr_rd;
			SRC_NT:      value = nt_rd;
			SRC_PAL:     value = pal_rd;
			SRC_PPU_OB:  value = ppu_ob_q;
			default:     value = ppu_ob_q;
		endcase
	end

	// The read in the stage is older than a beat accepted at the same edge,
	// so the accepted write's open-bus update takes priority.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cpu_ob_q <= '0;
			ppu_ob_q <= '0;
		end else begin
			if (accept && acc.cpu_ob_we) begin
				cpu_ob_q <= s_tdata[23:16];
			end else if (valid_s1 && adv &&
			             (src_s1 == SRC_PRG_RAM || src_s1 == SRC_PRG_ROM ||
			              src_s1 == SRC_CPU_OB)) begin
				cpu_ob_q <= value;
			end
			if (accept && acc.ppu_ob_we) begin
				ppu_ob_q <= s_tdata[23:16];
			end else if (valid_s1 && adv &&
			             (src_s1 == SRC_NT || src_s1 == SRC_PAL ||
			              src_s1 == SRC_PPU_OB)) begin
				ppu_ob_q <= value;
			end
		end
	end

	// ---------------- Output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q <= value;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------- Assertions ----------------
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> !s_tready)
		else $error("beat accepted during clearing sweep");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("input accepted while read stage is stalled");

	a_stage_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(valid_s1) |-> $past(rd_en))
		else $error("read stage filled without an accepted read");

	a_out_from_stage: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1))
		else $error("result appeared without a pending read");

endmodule

`default_nettype wire

/* rtl/cbd_ram.sv */
// ----------------------------------------------------------------------------
// cbd_ram
// Generic single-clock RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire                      clk,
	input  wire                      we,
	input  wire  [$clog2(DEPTH)-1:0] waddr,
	input  wire  [WIDTH-1:0]         wdata,
	input  wire                      re,
	input  wire  [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

/* rtl/cbd_decode.sv */
// ----------------------------------------------------------------------------
// cbd_decode
// Address decoder: turns one bus beat into the memory accesses it makes.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_decode
	import cbd_pkg::*;
(
	input  wire        [2:0]  operation,
	input  wire        [15:0] address,
	input  cfg_t              cfg,
	output acc_t              acc
);

	logic [11:0] nt_addr;
	logic [4:0]  pal_addr;
	logic        cpu_in_ram;
	logic        ppu_in_chr;
	logic        ppu_in_nt;
	logic        ppu_in_pal;

	always_comb begin
		nt_addr    = address[11:0];
		pal_addr   = address[4:0];
		cpu_in_ram = (address[15:13] == 3'b011);
		ppu_in_chr = (address[15:13] == 3'b000);
		ppu_in_nt  = !ppu_in_chr && (address < 16'h3F00);
		ppu_in_pal = !ppu_in_chr && !ppu_in_nt && (address[15:14] == 2'b00);

		acc             = '0;
		acc.src         = SRC_CPU_OB;
		acc.prg_ram_idx = address[PRG_RAM_AW-1:0];
		acc.chr_idx     = address[CHR_AW-1:0];
		// Horizontal mirroring moves bit 11 down into bit 10.
		acc.nt_idx      = cfg.mirror_mode ? {nt_addr[11], nt_addr[9:0]} : nt_addr[10:0];
		// Sprite backdrop entries share the background ones.
		acc.pal_idx     = (pal_addr[4] && pal_addr[1:0] == 2'b00) ?
		                  {1'b0, pal_addr[3:0]} : pal_addr;

		unique case (operation)
			OP_CPU_READ: begin
				acc.is_read     = 1'b1;
				acc.prg_rom_idx = {address[14] & ~cfg.prg_is_16k, address[13:0]};
				if (cpu_in_ram) begin
					acc.src = SRC_PRG_RAM;
				end else if (address[15]) begin
					acc.src = SRC_PRG_ROM;
				end
			end
			OP_CPU_WRITE: begin
				acc.prg_ram_we = cpu_in_ram;
				acc.cpu_ob_we  = 1'b1;
			end
			OP_PPU_READ: begin
				acc.is_read = 1'b1;
				if (ppu_in_chr) begin
					acc.src = SRC_CHR;
				end else if (ppu_in_nt) begin
					acc.src = SRC_NT;
				end else if (ppu_in_pal) begin
					acc.src = SRC_PAL;
				end else begin
					acc.src = SRC_PPU_OB;
				end
			end
			OP_PPU_WRITE: begin
				acc.chr_we    = ppu_in_chr && cfg.chr_is_ram;
				acc.nt_we     = ppu_in_nt;
				acc.pal_we    = ppu_in_pal;
				acc.ppu_ob_we = ppu_in_nt || ppu_in_pal;
			end
			OP_PRG_LOAD: begin
				acc.prg_rom_we  = 1'b1;
				acc.prg_rom_idx = address[PRG_IDX_W-1:0];
			end
			OP_CHR_LOAD: begin
				acc.chr_we = 1'b1;
			end
			default: begin
				acc.is_read = 1'b0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Stream and register-port testbench for the cartridge bus decoder core.
// A scoreboard class keeps its own image of every store, the two open-bus
// latches and the mapping settings. It works out the byte that each accepted
// read must return and compares the read results in order. The run begins
// with directed bus beats, then goes through several mapping settings with
// random beats. Reads of the stores that reset leaves undefined target only written locations.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
	import cbd_pkg::*;

	localparam int PRG_ROM_SZ   = 32768;
	localparam int BEATS_PER_SET = 75;

	class cart_image;
		logic [7:0] prg_rom [PRG_ROM_SZ];
		logic [7:0] chr [CHR_BYTES];
		logic [7:0] prg_ram [PRG_RAM_BYTES];
		logic [7:0] nt [NT_BYTES];
		logic [7:0] pal [PAL_BYTES];
		logic [7:0] cpu_bus;
		logic [7:0] ppu_bus;
		cfg_t       cfg;
		logic [7:0] pending_reads [$];
		int         mismatches;
		int         reads_checked;
		int         beats;

		function new();
			foreach (prg_rom[i]) prg_rom[i] = 8'h00;
			foreach (chr[i]) chr[i] = 8'h00;
			foreach (prg_ram[i]) prg_ram[i] = 8'h00;
			foreach (nt[i]) nt[i] = 8'h00;
			foreach (pal[i]) pal[i] = 8'h00;
			cpu_bus = 8'h00;
			ppu_bus = 8'h00;
			cfg.prg_is_16k = 1'b0;
			cfg.chr_is_ram = 1'b1;
			cfg.mirror_mode = 1'b0;
			mismatches = 0;
			reads_checked = 0;
			beats = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic v);
			case (idx)
				REG_PRG_IS_16K:  cfg.prg_is_16k = v;
				REG_CHR_IS_RAM:  cfg.chr_is_ram = v;
				REG_MIRROR_MODE: cfg.mirror_mode = v;
				default: ;
			endcase
		endfunction

		// Horizontal mirroring moves address bit 11 into slot bit 10.
		function logic [NT_AW-1:0] nt_slot(logic [15:0] addr);
			if (!cfg.mirror_mode)
				return addr[10:0];
			return {addr[11], addr[9:0]};
		endfunction

		function logic [PAL_AW-1:0] pal_slot(logic [15:0] addr);
			logic [4:0] p;
			p = addr[4:0];
			if (p[4] && p[1:0] == 2'b00)
				p[4] = 1'b0;
			return p;
		endfunction

		function logic [14:0] prg_slot(logic [15:0] addr);
			logic [14:0] idx;
			idx = addr[14:0];
			if (cfg.prg_is_16k)
				idx[14] = 1'b0;
			return idx;
		endfunction

		function void note_beat(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
			logic [7:0] v;
			beats++;
			case (op)
				OP_CPU_READ: begin
					if (addr >= 16'h6000 && addr <= 16'h7FFF)
						v = prg_ram[addr[12:0]];
					else if (addr[15])
						v = prg_rom[prg_slot(addr)];
					else
						v = cpu_bus;
					cpu_bus = v;
					pending_reads.push_back(v);
				end
				OP_CPU_WRITE: begin
					if (addr >= 16'h6000 && addr <= 16'h7FFF)
						prg_ram[addr[12:0]] = data;
					cpu_bus = data;
				end
				OP_PPU_READ: begin
					// CHR reads do not touch the PPU open-bus latch.
					if (addr < 16'h2000) begin
						pending_reads.push_back(chr[addr[12:0]]);
					end else begin
						if (addr < 16'h3F00)
							v = nt[nt_slot(addr)];
						else if (addr <= 16'h3FFF)
							v = pal[pal_slot(addr)];
						else
							v = ppu_bus;
						ppu_bus = v;
						pending_reads.push_back(v);
					end
				end
				OP_PPU_WRITE: begin
					if (addr < 16'h2000) begin
						if (cfg.chr_is_ram)
							chr[addr[12:0]] = data;
					end else if (addr < 16'h3F00) begin
						nt[nt_slot(addr)] = data;
						ppu_bus = data;
					end else if (addr <= 16'h3FFF) begin
						pal[pal_slot(addr)] = data;
						ppu_bus = data;
					end
				end
				OP_PRG_LOAD: prg_rom[addr[14:0]] = data;
				OP_CHR_LOAD: chr[addr[12:0]] = data;
				default: ;
			endcase
		endfunction

		function void check_read(logic [7:0] got);
			logic [7:0] want;
			if (pending_reads.size() == 0) begin
				$display("%0t: unexpected read beat, expected none, actual 0x%02h", $time, got);
				mismatches++;
				return;
			end
			want = pending_reads.pop_front();
			reads_checked++;
			if (got !== want) begin
				$display("%0t: read_data mismatch, expected 0x%02h, actual 0x%02h",
					$time, want, got);
				mismatches++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	wire  [31:0] prdata;
	wire         pready;
	logic        s_tvalid;
	wire         s_tready;
	logic [23:0] s_tdata;
	logic [2:0]  s_tuser;
	wire         m_tvalid;
	logic        m_tready;
	wire  [7:0]  m_tdata;

	cart_image sb;
	bit        steady;
	bit        held_off;

	// Locations of the undefined-at-reset stores that have been written,
	// plus touched PRG RAM and CHR addresses so reads hit real data.
	bit          prg_mark [PRG_ROM_SZ];
	bit          nt_mark [NT_BYTES];
	bit          pal_mark [PAL_BYTES];
	logic [14:0] prg_all_q [$];
	logic [14:0] prg_lo_q [$];
	logic [10:0] nt_q [$];
	logic [4:0]  pal_q [$];
	logic [15:0] ram_q [$];
	logic [15:0] chr_q [$];

	cartridge_bus_decoder_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[cartridge_bus_decoder_core] ERROR");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_read(m_tdata);
	end

	// Output side: random back-pressure, plus one long hold-off once traffic runs.
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held_off && sb.reads_checked >= 150) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end else begin
				m_tready <= steady || ($urandom_range(0, 99) >= 12);
			end
		end
	end

	task automatic cfg_write(logic [1:0] idx, logic v);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= ($urandom & 32'hFFFF_FFFE) | {31'd0, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic drain_reads();
		while (sb.pending_reads.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic drive_beat(logic [2:0] op, logic [15:0] addr, logic [7:0] data);
		logic [14:0] pi;
		logic [10:0] ni;
		logic [4:0]  qi;
		while (!steady && $urandom_range(0, 99) < 12) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
		end
		// Track what becomes defined; beats are accepted in the order issued.
		case (op)
			OP_CPU_WRITE: if (addr >= 16'h6000 && addr <= 16'h7FFF) ram_q.push_back(addr);
			OP_PPU_WRITE: begin
				if (addr < 16'h2000) begin
					chr_q.push_back(addr);
				end else if (addr < 16'h3F00) begin
					ni = sb.nt_slot(addr);
					if (!nt_mark[ni]) begin
						nt_mark[ni] = 1'b1;
						nt_q.push_back(ni);
					end
				end else if (addr <= 16'h3FFF) begin
					qi = sb.pal_slot(addr);
					if (!pal_mark[qi]) begin
						pal_mark[qi] = 1'b1;
						pal_q.push_back(qi);
					end
				end
			end
			OP_PRG_LOAD: begin
				pi = addr[14:0];
				if (!prg_mark[pi]) begin
					prg_mark[pi] = 1'b1;
					prg_all_q.push_back(pi);
					if (!pi[14])
						prg_lo_q.push_back(pi);
				end
			end
			OP_CHR_LOAD: chr_q.push_back({3'b000, addr[12:0]});
			default: ;
		endcase
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {data, addr};
		do @(posedge clk); while (!s_tready);
		sb.note_beat(op, addr, data);
	endtask

	task automatic random_beat();
		logic [2:0]  op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic [14:0] pw;
		logic [10:0] nw;
		logic [4:0]  qw;
		logic [11:0] a12;
		logic        b;
		int          roll;
		int          r;
		data = $urandom;
		addr = $urandom;
		roll = $urandom_range(0, 99);
		r = $urandom_range(0, 3);
		b = $urandom_range(0, 1);
		if (roll < 25) begin
			op = OP_CPU_READ;
			if (r == 0)
				addr = $urandom_range(0, 16'h5FFF);
			else if (r == 1 && ram_q.size() != 0 && b)
				addr = ram_q[$urandom_range(0, ram_q.size() - 1)];
			else if (r >= 2 && sb.cfg.prg_is_16k && prg_lo_q.size() != 0) begin
				pw = prg_lo_q[$urandom_range(0, prg_lo_q.size() - 1)];
				addr = {1'b1, b, pw[13:0]};
			end else if (r >= 2 && !sb.cfg.prg_is_16k && prg_all_q.size() != 0) begin
				pw = prg_all_q[$urandom_range(0, prg_all_q.size() - 1)];
				addr = {1'b1, pw};
			end else
				addr = $urandom_range(16'h6000, 16'h7FFF);
		end else if (roll < 37) begin
			op = OP_CPU_WRITE;
			if (b)
				addr = $urandom_range(16'h6000, 16'h7FFF);
		end else if (roll < 62) begin
			op = OP_PPU_READ;
			addr = $urandom_range(16'h4000, 16'hFFFF);
			if (r == 0) begin
				if (chr_q.size() != 0 && b)
					addr = chr_q[$urandom_range(0, chr_q.size() - 1)];
				else
					addr = $urandom_range(0, 16'h1FFF);
			end else if (r == 1 && nt_q.size() != 0) begin
				nw = nt_q[$urandom_range(0, nt_q.size() - 1)];
				if (!sb.cfg.mirror_mode)
					a12 = {b, nw};
				else
					a12 = {nw[10], b, nw[9:0]};
				addr = ($urandom_range(0, 1) ? 16'h3000 : 16'h2000) | {4'h0, a12};
				if (addr >= 16'h3F00)
					addr = 16'h2000 | {4'h0, a12};
			end else if (r == 2 && pal_q.size() != 0) begin
				qw = pal_q[$urandom_range(0, pal_q.size() - 1)];
				addr = {8'h3F, 3'($urandom_range(0, 7)), qw};
				// Entries 0, 4, 8 and C are also reached through their mirrors.
				if (!qw[4] && qw[1:0] == 2'b00 && b)
					addr[4] = 1'b1;
			end
		end else if (roll < 77) begin
			op = OP_PPU_WRITE;
			case (r)
				0: addr = $urandom_range(0, 16'h1FFF);
				1: addr = $urandom_range(16'h2000, 16'h3EFF);
				2: addr = $urandom_range(16'h3F00, 16'h3FFF);
				default: addr = $urandom_range(16'h4000, 16'hFFFF);
			endcase
		end else if (roll < 87) begin
			op = OP_PRG_LOAD;
		end else if (roll < 95) begin
			op = OP_CHR_LOAD;
		end else begin
			op = 3'($urandom_range(6, 7));
		end
		drive_beat(op, addr, data);
	endtask

	initial begin
		// {prg_is_16k, chr_is_ram, mirror_mode} for each random stretch.
		cfg_t plan [6];
		plan[0] = 3'b101;
		plan[1] = 3'b011;
		plan[2] = 3'b110;
		plan[3] = 3'b000;
		plan[4] = 3'b100;
		plan[5] = 3'b111;
		sb = new();
		steady = 1'b0;
		held_off = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 4'd0;
		pwdata = 32'd0;
		s_tvalid = 1'b0;
		s_tdata = 24'd0;
		s_tuser = 3'd0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats under the reset settings: 32 KB PRG, CHR RAM, vertical.
		drive_beat(OP_PRG_LOAD, 16'h0000, 8'hA5);
		drive_beat(OP_PRG_LOAD, 16'h3FFF, 8'h5A);
		drive_beat(OP_PRG_LOAD, 16'h4000, 8'hFF);
		drive_beat(OP_PRG_LOAD, 16'hFFFF, 8'h00);
		drive_beat(OP_CPU_READ, 16'h8000, 8'h00);
		drive_beat(OP_CPU_READ, 16'hFFFF, 8'hFF);
		drive_beat(OP_CPU_READ, 16'hBFFF, 8'h00);
		drive_beat(OP_CPU_READ, 16'h0000, 8'h00);
		drive_beat(OP_CPU_WRITE, 16'h6000, 8'hFF);
		drive_beat(OP_CPU_WRITE, 16'h7FFF, 8'h81);
		drive_beat(OP_CPU_WRITE, 16'h5FFF, 8'h3C);
		drive_beat(OP_CPU_READ, 16'h4020, 8'h00);
		drive_beat(OP_CPU_READ, 16'h6000, 8'h00);
		drive_beat(OP_CHR_LOAD, 16'hFFFF, 8'h77);
		drive_beat(OP_PPU_READ, 16'h1FFF, 8'h00);
		drive_beat(OP_PPU_WRITE, 16'h0000, 8'h12);
		drive_beat(OP_PPU_READ, 16'h0000, 8'h00);
		drive_beat(OP_PPU_WRITE, 16'h2000, 8'hE1);
		drive_beat(OP_PPU_WRITE, 16'h3EFF, 8'h1E);
		drive_beat(OP_PPU_READ, 16'h2800, 8'h00);
		drive_beat(OP_PPU_WRITE, 16'h3F10, 8'h2D);
		drive_beat(OP_PPU_WRITE, 16'h3FFF, 8'hD2);
		drive_beat(OP_PPU_READ, 16'h3F00, 8'h00);
		drive_beat(OP_PPU_READ, 16'h3FFF, 8'h00);
		drive_beat(OP_PPU_WRITE, 16'hFFFF, 8'h99);
		drive_beat(OP_PPU_READ, 16'h4000, 8'h00);
		drive_beat(3'd6, 16'h1234, 8'h56);
		drive_beat(3'd7, 16'hEDCB, 8'hA9);

		for (int ph = 0; ph < 6; ph++) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			drain_reads();
			cfg_write(REG_PRG_IS_16K, plan[ph].prg_is_16k);
			cfg_write(REG_CHR_IS_RAM, plan[ph].chr_is_ram);
			cfg_write(REG_MIRROR_MODE, plan[ph].mirror_mode);
			// One whole stretch runs back to back on both sides.
			steady = (ph == 2);
			for (int n = 0; n < BEATS_PER_SET; n++)
				random_beat();
		end
		steady = 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b0;
		drain_reads();
		repeat (8) @(posedge clk);

		if (sb.pending_reads.size() != 0) begin
			$display("%0t: %0d reads never returned, expected 0x%02h first, actual none",
				$time, sb.pending_reads.size(), sb.pending_reads[0]);
			sb.mismatches++;
		end
		$display("Ran %0d beats with %0d reads compared across 7 mapping settings.",
			sb.beats, sb.reads_checked);
		$display("Covered both PRG sizes, CHR as RAM and ROM, both mirrorings and a long stall.");
		if (sb.mismatches == 0) begin
			$display("[cartridge_bus_decoder_core] OK");
		end else begin
			$display("[cartridge_bus_decoder_core] ERROR");
		end
		$finish;
	end

endmodule

`default_nettype wire
